@@ src/tacs_pkg.sv @@
// Package for the tiny accumulator CPU step block.
// Holds opcodes, command codes, load destination codes and shared constants.
package tacs_pkg;

  localparam int unsigned PROG_DEPTH_DEF = 1024;
  localparam logic [15:0] HALT_PC        = 16'hFFFF;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } command_e;

  typedef enum logic [3:0] {
    OP_NOP   = 4'h0,
    OP_LD_A  = 4'h1,
    OP_LD_B  = 4'h2,
    OP_LD_C  = 4'h3,
    OP_LI_A  = 4'h4,
    OP_LI_B  = 4'h5,
    OP_LI_C  = 4'h6,
    OP_ST_A  = 4'h7,
    OP_ST_B  = 4'h8,
    OP_ST_C  = 4'h9,
    OP_ADD   = 4'hA,
    OP_SUB   = 4'hB,
    OP_JMP   = 4'hC,
    OP_JMNZ  = 4'hD,
    OP_SWP_B = 4'hE,
    OP_SWP_C = 4'hF
  } opcode_e;

  // Register waiting for data memory read data
  typedef enum logic [1:0] {
    DEST_NONE = 2'd0,
    DEST_A    = 2'd1,
    DEST_B    = 2'd2,
    DEST_C    = 2'd3
  } dest_e;

endpackage

@@ src/tiny_accumulator_cpu_step_top.sv @@
// Tiny accumulator CPU, one word per command: program load or single step.
// Depends on tacs_pkg. An accepted word passes the stage-two and output registers.
// Throughput: one word per cycle unless stalled; the fetch register is kept on the next
// PC and data memory reads are forwarded into the registers, so no step waits on another.
// Reset: asynchronous, active low; clears PC, A, B, C, zero flag, the data memory valid
// bits (unwritten bytes read as zero) and the pipeline. The program store is not cleared.
module tiny_accumulator_cpu_step_top #(
  parameter int unsigned PROG_DEPTH = tacs_pkg::PROG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [9:0]  load_address_i,
  input  logic [15:0] load_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] program_counter_o,
  output logic [7:0]  acc_a_o,
  output logic [7:0]  gen_b_o,
  output logic [7:0]  gen_c_o,
  output logic        zero_flag_o,
  output logic        halted_o
);
  import tacs_pkg::*;

  localparam int unsigned AW = $clog2(PROG_DEPTH);

  // Program store: one write port (load command), one read port that always
  // tracks the PC the next step will execute.
  logic [15:0] prog_mem [PROG_DEPTH];
  logic [15:0] prog_rd_q;
  logic [15:0] fwd_word_q;
  logic        fwd_q;
  logic        oob_q;

  // Data memory with per-byte valid bits standing in for the reset clear.
  logic [7:0]   data_mem [256];
  logic [255:0] dvalid_q;
  logic [7:0]   dm_rd_q;
  logic         dm_rvalid_q;

  // Architectural state
  logic [15:0] pc_q, pc_d, pc_n;
  logic [7:0]  a_q, b_q, c_q;
  logic [7:0]  a_d, b_d, c_d;
  logic [7:0]  a_n, b_n, c_n;
  logic        zero_q, zero_d;
  dest_e       pend_q, pend_n, pend_d;

  // Pipeline control
  logic        s2_valid_q;
  logic        out_valid_q;
  logic        adv;
  logic        in_acc;
  logic        exec;

  // Output register
  logic [15:0] out_pc_q;
  logic [7:0]  out_a_q, out_b_q, out_c_q;
  logic        out_zero_q, out_halt_q;

  // Decode and forwarding
  logic [15:0] word;
  opcode_e     opcode;
  logic [7:0]  imm;
  logic [7:0]  dm_rd_eff;
  logic [7:0]  a_eff, b_eff, c_eff;
  logic        dm_we;
  logic [7:0]  dm_wdata;

  // Program store addressing
  logic [16:0]   wr_ext, rd_ext;
  logic          prog_we;
  logic          rd_in_range;
  logic [AW-1:0] wr_idx, rd_idx;

  // Whole pipe moves together; hold everything while the output word is stalled.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign exec       = in_acc && (command_i == CMD_STEP) && (pc_q != HALT_PC);

  // Instruction word at pc_q: bypass a same-cycle load, NOP beyond the store.
  assign word   = oob_q ? 16'h0000 : (fwd_q ? fwd_word_q : prog_rd_q);
  assign opcode = opcode_e'(word[15:12]);
  assign imm    = word[7:0];

  // A load issued by the previous step lands here; forward it into A, B or C.
  assign dm_rd_eff = dm_rvalid_q ? dm_rd_q : 8'h00;
  assign a_eff     = (pend_q == DEST_A) ? dm_rd_eff : a_q;
  assign b_eff     = (pend_q == DEST_B) ? dm_rd_eff : b_q;
  assign c_eff     = (pend_q == DEST_C) ? dm_rd_eff : c_q;

  // Execute
  always_comb begin
    a_n      = a_eff;
    b_n      = b_eff;
    c_n      = c_eff;
    pc_n     = pc_q + 16'd1;
    pend_n   = DEST_NONE;
    dm_we    = 1'b0;
    dm_wdata = a_eff;
    unique case (opcode)
      OP_NOP: begin
      end
      OP_LD_A:  pend_n = DEST_A;
      OP_LD_B:  pend_n = DEST_B;
      OP_LD_C:  pend_n = DEST_C;
      OP_LI_A:  a_n = imm;
      OP_LI_B:  b_n = imm;
      OP_LI_C:  c_n = imm;
      OP_ST_A: begin
        dm_we    = 1'b1;
        dm_wdata = a_eff;
      end
      OP_ST_B: begin
        dm_we    = 1'b1;
        dm_wdata = b_eff;
      end
      OP_ST_C: begin
        dm_we    = 1'b1;
        dm_wdata = c_eff;
      end
      OP_ADD:   a_n = a_eff + b_eff;
      OP_SUB:   a_n = a_eff - b_eff;
      OP_JMP:   pc_n = {8'h00, imm};
      OP_JMNZ: begin
        if (a_eff != 8'h00) begin
          pc_n = {8'h00, imm};
        end
      end
      OP_SWP_B: begin
        a_n = b_eff;
        b_n = a_eff;
      end
      OP_SWP_C: begin
        a_n = c_eff;
        c_n = a_eff;
      end
    endcase
  end

  // Fold the forwarded value back into the registers on every advance.
  always_comb begin
    if (exec) begin
      a_d    = a_n;
      b_d    = b_n;
      c_d    = c_n;
      pc_d   = pc_n;
      zero_d = (a_eff == 8'h00);
      pend_d = pend_n;
    end else begin
      a_d    = a_eff;
      b_d    = b_eff;
      c_d    = c_eff;
      pc_d   = pc_q;
      zero_d = zero_q;
      pend_d = DEST_NONE;
    end
  end

  // Program store addressing; drop loads beyond the depth.
  assign wr_ext      = 17'(load_address_i);
  assign prog_we     = in_acc && (command_i == CMD_LOAD) && (wr_ext < 17'(PROG_DEPTH));
  assign wr_idx      = wr_ext[AW-1:0];
  assign rd_ext      = 17'(pc_d);
  assign rd_in_range = rd_ext < 17'(PROG_DEPTH);
  assign rd_idx      = rd_in_range ? rd_ext[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[wr_idx] <= load_word_i;
    end
    prog_rd_q  <= prog_mem[rd_idx];
    fwd_word_q <= load_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      oob_q <= 1'b0;
    end else begin
      fwd_q <= prog_we && (wr_idx == rd_idx);
      oob_q <= !rd_in_range;
    end
  end

  // Data memory: read at the immediate, write on a store step.
  always_ff @(posedge clk_i) begin
    if (exec && dm_we) begin
      data_mem[imm] <= dm_wdata;
    end
    if (adv) begin
      dm_rd_q     <= data_mem[imm];
      dm_rvalid_q <= dvalid_q[imm];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
    end else if (exec && dm_we) begin
      dvalid_q[imm] <= 1'b1;
    end
  end

  // Architectural registers and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= 16'h0000;
      a_q         <= 8'h00;
      b_q         <= 8'h00;
      c_q         <= 8'h00;
      zero_q      <= 1'b0;
      pend_q      <= DEST_NONE;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pc_q        <= pc_d;
      a_q         <= a_d;
      b_q         <= b_d;
      c_q         <= c_d;
      zero_q      <= zero_d;
      pend_q      <= pend_d;
      s2_valid_q  <= in_acc;
      out_valid_q <= s2_valid_q;
    end
  end

  // Capture the state after the second-stage word, load data included.
  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_pc_q   <= pc_q;
      out_a_q    <= a_eff;
      out_b_q    <= b_eff;
      out_c_q    <= c_eff;
      out_zero_q <= zero_q;
      out_halt_q <= (pc_q == HALT_PC);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign program_counter_o = out_pc_q;
  assign acc_a_o           = out_a_q;
  assign gen_b_o           = out_b_q;
  assign gen_c_o           = out_c_q;
  assign zero_flag_o       = out_zero_q;
  assign halted_o          = out_halt_q;

endmodule

@@ src/tacs_chk.sv @@
// Port-level checker for the tiny accumulator CPU step block.
// Depends on tacs_pkg; bound to tiny_accumulator_cpu_step_top below.
module tacs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] program_counter_o,
  input logic [7:0]  acc_a_o,
  input logic [7:0]  gen_b_o,
  input logic [7:0]  gen_c_o,
  input logic        zero_flag_o,
  input logic        halted_o
);
  import tacs_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(program_counter_o)
      && $stable(acc_a_o) && $stable(gen_b_o) && $stable(gen_c_o)
      && $stable(zero_flag_o) && $stable(halted_o))
    else $error("stalled result word changed");

  // Input stalls exactly when a full output is stalled.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  // Halt flag reports a PC of all ones.
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (halted_o == (program_counter_o == HALT_PC)))
    else $error("halt flag disagrees with PC");

  // An accepted word yields a result word, given no output stall after it is accepted.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("result word missing");

endmodule

bind tiny_accumulator_cpu_step_top tacs_chk u_tacs_chk (.*);
